// ----- rtl/dtcl_pkg.sv -----
// ----------------------------------------------------------------------------
// dtcl_pkg
// shared types, character codes and the line pattern of the date/time parser
// ----------------------------------------------------------------------------
package dtcl_pkg;

    localparam int BYTE_W            = 8;
    localparam int DEF_LINE_CAPACITY = 21;
    localparam int MIN_LINE          = 19;                 // DD/MM/YYYY HH:MM:SS
    localparam int POS_W             = $clog2(MIN_LINE + 1);
    localparam int NUM_DIGITS        = 14;
    localparam int DIG_W             = 4 * NUM_DIGITS;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'd47;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'd58;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MIN_LINE - 1);

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_BADFMT  = 2'd2,
        ST_TOOLONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PK_DIGIT = 2'd0,
        PK_SLASH = 2'd1,
        PK_SPACE = 2'd2,
        PK_COLON = 2'd3
    } t_pat_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        t_status           line_status;
        logic [7:0]        day_bcd;
        logic [7:0]        month_bcd;
        logic [15:0]       year_bcd;
        logic [7:0]        hour_bcd;
        logic [7:0]        minute_bcd;
        logic [7:0]        second_bcd;
    } t_result;

    // what the pattern expects at each line position
    function automatic t_pat_kind f_pat_kind(input logic [POS_W-1:0] pos);
        t_pat_kind kind;
        unique case (pos)
            POS_W'(2), POS_W'(5):   kind = PK_SLASH;
            POS_W'(10):             kind = PK_SPACE;
            POS_W'(13), POS_W'(16): kind = PK_COLON;
            default:                kind = PK_DIGIT;
        endcase
        return kind;
    endfunction

    function automatic logic f_char_ok(input t_pat_kind kind, input logic [BYTE_W-1:0] c);
        logic ok;
        unique case (kind)
            PK_SLASH: ok = (c == CHAR_SLASH);
            PK_SPACE: ok = (c == CHAR_SPACE);
            PK_COLON: ok = (c == CHAR_COLON);
            default:  ok = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/dtcl_if.sv -----
// ----------------------------------------------------------------------------
// dtcl_if
// valid/ready channels of the parser: received byte in, result beat out
// ----------------------------------------------------------------------------
interface dtcl_rx_if;
    import dtcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dtcl_res_if;
    import dtcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] echo_byte;
    logic [1:0]        line_status;
    logic [7:0]        day_bcd;
    logic [7:0]        month_bcd;
    logic [15:0]       year_bcd;
    logic [7:0]        hour_bcd;
    logic [7:0]        minute_bcd;
    logic [7:0]        second_bcd;

    modport source (output valid, output echo_byte, output line_status, output day_bcd,
                    output month_bcd, output year_bcd, output hour_bcd, output minute_bcd,
                    output second_bcd, input ready);
    modport sink   (input valid, input echo_byte, input line_status, input day_bcd,
                    input month_bcd, input year_bcd, input hour_bcd, input minute_bcd,
                    input second_bcd, output ready);
endinterface

// ----- rtl/dtcl_line_ram.sv -----
// ----------------------------------------------------------------------------
// dtcl_line_ram
// line store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dtcl_line_ram #(
    parameter int DEPTH = dtcl_pkg::DEF_LINE_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [dtcl_pkg::BYTE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [dtcl_pkg::BYTE_W-1:0] o_rdata
);
    import dtcl_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/datetime_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// datetime_command_line_parser
// echoes serial bytes, collects a line and decodes DD/MM/YYYY HH:MM:SS to bcd
// ----------------------------------------------------------------------------
// usage
//   i_rx  : one received character per beat (valid/ready)
//   o_res : one result beat per received character: the echoed byte, a line
//           status and six bcd fields that are nonzero only for an accepted line
//   an ordinary character is written to the line store in the work state and
//   its result is loaded into the output register from the emit state; the
//   next character is taken only once the parser is back in idle
//   a carriage return starts a walk over the first 19 stored characters
//   through the single read port of the line store, one character per cycle,
//   and its result then goes through the emit state to the output register;
//   the next character is taken only once the parser is back in idle
//   a line shorter than 19 characters is rejected without the walk
//   i_rx.ready is high only while no character is in work; one new character
//   is taken while the previous result still sits in the output register
//   when the receiver stalls o_res, the finished result waits in the parser
//   and no further character is taken until the output register frees up
//   reset (synchronous, active low) empties the line and the output register;
//   the line store itself is not cleared, only written positions are read
// ----------------------------------------------------------------------------
module datetime_command_line_parser #(
    parameter int LINE_CAPACITY = dtcl_pkg::DEF_LINE_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtcl_rx_if.sink           i_rx,
    dtcl_res_if.source        o_res
);
    import dtcl_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);       // store address
    localparam int CW = $clog2(LINE_CAPACITY + 1);   // count up to full

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a character
        S_WORK = 4'b0010,   // store the character, drop it when full, or decide on carriage return
        S_SCAN = 4'b0100,   // walk the line against the pattern
        S_EMIT = 4'b1000    // hand the result to the output register
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_byte,  n_byte;
    logic [POS_W-1:0]  r_idx,   n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [POS_W-1:0]  r_rd_pos, n_rd_pos;
    logic              r_ok,    n_ok;
    logic [DIG_W-1:0]  r_dig,   n_dig;
    t_result           r_res,   n_res;
    logic              r_out_vld, n_out_vld;
    t_result           r_out,   n_out;

    // line store port
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // compare unit shared by all positions of the walk
    t_pat_kind         pat_kind;
    logic              char_ok;
    logic              line_ok;
    logic [DIG_W-1:0]  dig_shift;

    dtcl_line_ram #(
        .DEPTH (LINE_CAPACITY),
        .AW    (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pat_kind  = f_pat_kind(r_rd_pos);
    assign char_ok   = f_char_ok(pat_kind, ram_rdata);
    assign line_ok   = r_ok & char_ok;
    // a digit's low nibble is its bcd value
    assign dig_shift = {r_dig[DIG_W-5:0], ram_rdata[3:0]};

    assign i_rx.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_byte    = r_byte;
        n_idx     = r_idx;
        n_ok      = r_ok;
        n_dig     = r_dig;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_raddr = AW'(r_idx);

        // output register drains independently of the sequencer
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_rx.valid) begin
                    n_byte  = i_rx.rx_byte;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                n_res             = '0;
                n_res.echo_byte   = r_byte;
                n_res.line_status = ST_STORED;
                priority if (r_byte == CHAR_CR) begin
                    n_count = '0;
                    if (r_count < CW'(MIN_LINE)) begin
                        // short or empty line: no walk needed
                        n_res.line_status = ST_BADFMT;
                        n_state           = S_EMIT;
                    end else begin
                        n_idx   = '0;
                        n_ok    = 1'b1;
                        n_state = S_SCAN;
                    end
                end else if (r_count >= CW'(LINE_CAPACITY)) begin
                    // store full: byte dropped, line restarts
                    n_res.line_status = ST_TOOLONG;
                    n_count           = '0;
                    n_state           = S_EMIT;
                end else begin
                    ram_we  = 1'b1;
                    n_count = CW'(r_count + 1'b1);
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                // issue one read a cycle, check the data of the previous read
                ram_re = (r_idx < POS_W'(MIN_LINE));
                if (ram_re) begin
                    n_idx = POS_W'(r_idx + 1'b1);
                end
                if (r_rd_vld) begin
                    n_ok = line_ok;
                    if (pat_kind == PK_DIGIT) begin
                        n_dig = dig_shift;
                    end
                    if (r_rd_pos == LAST_POS) begin
                        n_state = S_EMIT;
                        if (line_ok) begin
                            n_res.line_status = ST_ACCEPT;
                            n_res.day_bcd     = dig_shift[55:48];
                            n_res.month_bcd   = dig_shift[47:40];
                            n_res.year_bcd    = dig_shift[39:24];
                            n_res.hour_bcd    = dig_shift[23:16];
                            n_res.minute_bcd  = dig_shift[15:8];
                            n_res.second_bcd  = dig_shift[7:0];
                        end else begin
                            n_res.line_status = ST_BADFMT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_vld = ram_re;
        n_rd_pos = r_idx;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_idx    <= n_idx;
        r_rd_pos <= n_rd_pos;
        r_ok     <= n_ok;
        r_dig    <= n_dig;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.echo_byte   = r_out.echo_byte;
    assign o_res.line_status = r_out.line_status;
    assign o_res.day_bcd     = r_out.day_bcd;
    assign o_res.month_bcd   = r_out.month_bcd;
    assign o_res.year_bcd    = r_out.year_bcd;
    assign o_res.hour_bcd    = r_out.hour_bcd;
    assign o_res.minute_bcd  = r_out.minute_bcd;
    assign o_res.second_bcd  = r_out.second_bcd;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LINE_CAPACITY))
        else $error("line count beyond store capacity");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= POS_W'(MIN_LINE)))
        else $error("walk index past pattern end");

    a_accept_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.line_status == ST_ACCEPT) |-> (r_out.echo_byte == CHAR_CR))
        else $error("accepted line on a beat that is not carriage return");

    a_bcd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.line_status != ST_ACCEPT) |->
            ({r_out.day_bcd, r_out.month_bcd, r_out.year_bcd, r_out.hour_bcd,
              r_out.minute_bcd, r_out.second_bcd} == '0))
        else $error("bcd fields set on a beat without accepted line");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_out_vld) |=> (r_out_vld && r_state == S_IDLE))
        else $error("result not loaded into free output register");
`endif

endmodule

// ----- tb/tb_datetime_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// tb_datetime_command_line_parser
// self-checking bench for the serial date/time line parser
// ----------------------------------------------------------------------------
// every received byte accepted on the input channel is run through a local
// line decoder that keeps its own copy of the line buffer. Each result beat
// is checked field by field against the oldest decoded result. Stimulus is a
// short directed run followed by well-formed DD/MM/YYYY HH:MM:SS
// lines with random digits, mixed with corrupted, short and overlong lines
// and raw noise bytes, under three idle profiles and one long receiver stall
// ----------------------------------------------------------------------------
module tb_datetime_command_line_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import dtcl_pkg::*;

    localparam int LINE_CAP   = DEF_LINE_CAPACITY;
    // long receiver hold-off, in cycles, used once to back the parser up
    localparam int HOLD_CYCLES = 300;
    // quiet cycles tolerated before giving up
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last result
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    dtcl_rx_if  rx_if ();
    dtcl_res_if res_if ();

    datetime_command_line_parser #(
        .LINE_CAPACITY (LINE_CAP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------
    // decoder state, mirror of the parser's line buffer
    // ------------------------------------------------------------------
    logic [7:0] line_chars [0:LINE_CAP-1];
    int         line_len;

    // bytes waiting to be sent and decoded results waiting for their beat
    logic [7:0] tx_chars [$];
    t_result    awaited_decodes [$];

    int chars_queued;
    int chars_sent;
    int mismatches;
    int lines_accepted;
    int lines_rejected;
    int lines_overflowed;

    // idle percentages of both sides, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    // long hold-off requests from the stimulus, served by the receiver
    int hold_requested;
    int hold_served;
    int hold_left;
    int quiet_cycles;

    // does character c fit the date/time pattern at line position pos
    function automatic logic char_fits(input int pos, input logic [7:0] c);
        case (pos)
            2, 5:    return c == CHAR_SLASH;
            10:      return c == CHAR_SPACE;
            13, 16:  return c == CHAR_COLON;
            default: return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        endcase
    endfunction

    // two stored digit characters packed as one bcd byte
    function automatic logic [7:0] bcd_at(input int pos);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = line_chars[pos] - CHAR_ZERO;
        lo = line_chars[pos + 1] - CHAR_ZERO;
        return {hi[3:0], lo[3:0]};
    endfunction

    // advance the line buffer by one received byte and return its result
    function automatic t_result decode_rx_byte(input logic [7:0] c);
        t_result r;
        logic    ok;
        r             = '0;
        r.echo_byte   = c;
        r.line_status = ST_STORED;
        if (c == CHAR_CR) begin
            // only positions written in this line are looked at
            ok = (line_len >= MIN_LINE);
            for (int i = 0; i < MIN_LINE; i++) begin
                if (ok && !char_fits(i, line_chars[i]))
                    ok = 1'b0;
            end
            if (ok) begin
                r.line_status = ST_ACCEPT;
                r.day_bcd     = bcd_at(0);
                r.month_bcd   = bcd_at(3);
                r.year_bcd    = {bcd_at(6), bcd_at(8)};
                r.hour_bcd    = bcd_at(11);
                r.minute_bcd  = bcd_at(14);
                r.second_bcd  = bcd_at(17);
            end else begin
                r.line_status = ST_BADFMT;
            end
            line_len = 0;
        end else if (line_len >= LINE_CAP) begin
            // buffer full: byte dropped and the line thrown away
            r.line_status = ST_TOOLONG;
            line_len      = 0;
        end else begin
            line_chars[line_len] = c;
            line_len++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c);
        tx_chars.push_back(c);
        chars_queued++;
    endtask

    function automatic logic [7:0] any_but_cr();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == CHAR_CR)
            c = 8'hFF;
        return c;
    endfunction

    // a character that fits the pattern at pos, digits drawn at random
    function automatic logic [7:0] fitting_char(input int pos);
        case (pos)
            2, 5:    return CHAR_SLASH;
            10:      return CHAR_SPACE;
            13, 16:  return CHAR_COLON;
            default: return CHAR_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    // a character likely to break the pattern at pos, biased to near misses
    function automatic logic [7:0] misfit_char(input int pos);
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0:       return any_but_cr();
            1:       return CHAR_ZERO - 8'd1;   // just below the digits
            2:       return CHAR_NINE + 8'd1;   // just above the digits
            default: begin
                if (char_fits(pos, CHAR_ZERO)) begin
                    case ($urandom_range(2))
                        0:       return CHAR_SLASH;
                        1:       return CHAR_SPACE;
                        default: return CHAR_COLON;
                    endcase
                end
                return CHAR_ZERO + 8'($urandom_range(9));
            end
        endcase
    endfunction

    // keep pattern characters, one of them optionally broken, then
    // trailing junk and a carriage return
    task automatic queue_date_line(input int keep, input int bad_pos, input int extra);
        logic [7:0] c;
        for (int i = 0; i < keep; i++) begin
            c = (i == bad_pos) ? misfit_char(i) : fitting_char(i);
            push_char(c);
        end
        for (int i = 0; i < extra; i++)
            push_char(any_but_cr());
        push_char(CHAR_CR);
    endtask

    // more bytes than the buffer holds, sometimes with a valid-looking start
    task automatic queue_long_line();
        int n;
        int shaped;
        n      = $urandom_range(LINE_CAP + 1, LINE_CAP + 5);
        shaped = $urandom_range(1);
        for (int i = 0; i < n; i++)
            push_char((shaped != 0 && i < MIN_LINE) ? fitting_char(i) : any_but_cr());
        push_char(CHAR_CR);
    endtask

    task automatic queue_random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            queue_date_line(MIN_LINE, -1, $urandom_range(2));
        end else if (pick < 65) begin
            queue_date_line(MIN_LINE, $urandom_range(MIN_LINE - 1), $urandom_range(2));
        end else if (pick < 75) begin
            queue_date_line($urandom_range(MIN_LINE - 1), -1, 0);
        end else if (pick < 85) begin
            queue_long_line();
        end else begin
            // raw noise, carriage returns included
            repeat ($urandom_range(1, 6))
                push_char(8'($urandom_range(255)));
        end
    endtask

    // hold the sender until every queued byte has been answered
    task automatic wait_drained();
        while (chars_sent != chars_queued || awaited_decodes.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // clock and initial values of every driven signal
    // ------------------------------------------------------------------
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // driver: offers queued bytes, decodes each byte on its accepting beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        nxt_valid = rx_if.valid;
        nxt_byte  = rx_if.rx_byte;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                awaited_decodes.push_back(decode_rx_byte(rx_if.rx_byte));
                chars_sent++;
                nxt_valid = 1'b0;
            end
            // next byte only when the slot is free and no random gap is taken
            if (!nxt_valid && tx_chars.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_byte  = tx_chars.pop_front();
            end
        end
        rx_if.valid   <= nxt_valid;
        rx_if.rx_byte <= nxt_byte;
    end

    // ------------------------------------------------------------------
    // monitor: checks result beats and drives ready
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        logic    nxt_ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_decodes.size() == 0) begin
                $error("result beat with no byte behind it: echo_byte %0h",
                       res_if.echo_byte);
                mismatches++;
            end else begin
                want = awaited_decodes.pop_front();
                check_field("echo_byte",   16'(want.echo_byte),   16'(res_if.echo_byte));
                check_field("line_status", 16'(want.line_status), 16'(res_if.line_status));
                check_field("day_bcd",     16'(want.day_bcd),     16'(res_if.day_bcd));
                check_field("month_bcd",   16'(want.month_bcd),   16'(res_if.month_bcd));
                check_field("year_bcd",    want.year_bcd,         res_if.year_bcd);
                check_field("hour_bcd",    16'(want.hour_bcd),    16'(res_if.hour_bcd));
                check_field("minute_bcd",  16'(want.minute_bcd),  16'(res_if.minute_bcd));
                check_field("second_bcd",  16'(want.second_bcd),  16'(res_if.second_bcd));
                case (want.line_status)
                    ST_ACCEPT:  lines_accepted++;
                    ST_BADFMT:  lines_rejected++;
                    ST_TOOLONG: lines_overflowed++;
                    default:    ;
                endcase
            end
        end
        // long hold-off: ready stays low for a counted stretch
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_served < hold_requested) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        nxt_ready = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        res_if.ready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat for %0d cycles, %0d bytes sent, %0d results open",
                     quiet_cycles, chars_sent, awaited_decodes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        line_len         = 0;
        chars_queued     = 0;
        chars_sent       = 0;
        mismatches       = 0;
        lines_accepted   = 0;
        lines_rejected   = 0;
        lines_overflowed = 0;
        hold_requested   = 0;
        hold_served      = 0;
        hold_left        = 0;
        quiet_cycles     = 0;

        // phase one: sender idles a little, receiver a lot
        send_idle_pct = 10;
        recv_idle_pct = 47;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty line, then a full-buffer line of all-nine digits
        // with the two extreme byte values as ignored trailing characters
        push_char(CHAR_CR);
        for (int i = 0; i < MIN_LINE; i++)
            push_char(char_fits(i, CHAR_NINE) ? CHAR_NINE : fitting_char(i));
        push_char(8'hFF);
        push_char(8'h00);
        push_char(CHAR_CR);

        while (chars_queued < 250)
            queue_random_sequence();
        wait_drained();

        // phase two: the other way round, with one long receiver stall
        // while the sender keeps offering, so the parser backs up
        send_idle_pct = 47;
        recv_idle_pct = 10;
        while (chars_queued < 480)
            queue_random_sequence();
        hold_requested++;
        wait_drained();

        // phase three: back-to-back beats on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_queued < 700)
            queue_random_sequence();
        wait_drained();

        // catch any stray beat after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes: %0d lines decoded, %0d lines rejected, %0d overflows",
                 chars_sent, lines_accepted, lines_rejected, lines_overflowed);
        $display("three idle profiles and one %0d-cycle receiver stall, %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && awaited_decodes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- datetime_command_line_parser.f -----
rtl/dtcl_pkg.sv
rtl/dtcl_if.sv
rtl/dtcl_line_ram.sv
rtl/datetime_command_line_parser.sv
tb/tb_datetime_command_line_parser.sv
